// ===== hw/rtl/lpbc_pkg.sv =====
// Shared types, constants and the fade ROM builder for the LED pattern and button controller.
package lpbc_pkg;

    localparam int unsigned CfgW             = 16;
    localparam int unsigned LevelW           = 8;
    localparam int unsigned FadePhaseW       = 11;
    localparam int unsigned FadePeriodDefault = 2000;
    localparam int unsigned FadePeriodMax    = 2047;

    localparam logic [CfgW-1:0]   BlinkPeriodReset = 16'd400;
    localparam logic [CfgW-1:0]   DebounceReset    = 16'd50;
    localparam logic [CfgW-1:0]   LongPressReset   = 16'd1500;
    localparam logic [CfgW-1:0]   ToneReset        = 16'd300;
    localparam logic [CfgW-1:0]   TimerSat         = 16'hFFFF;
    localparam logic [LevelW-1:0] LevelFull        = 8'hFF;
    localparam logic [LevelW-1:0] LevelDark        = 8'h00;

    typedef enum logic [1:0] {
        LIGHT_OFF,
        LIGHT_ALT,
        LIGHT_ALL_ON,
        LIGHT_FADE
    } light_mode_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_MODE,
        EV_BOOT,
        EV_LONG,
        EV_MAN_ON,
        EV_MAN_OFF
    } event_t;

    typedef enum logic [1:0] {
        CFG_BLINK_PERIOD,
        CFG_DEBOUNCE,
        CFG_LONG_PRESS,
        CFG_TONE
    } cfg_index_t;

    typedef struct packed {
        logic mode;
        logic action;
        logic boot;
    } buttons_t;

    typedef struct packed {
        logic [CfgW-1:0] blink_period;
        logic [CfgW-1:0] debounce;
        logic [CfgW-1:0] long_press;
        logic [CfgW-1:0] tone;
    } cfg_t;

    typedef struct packed {
        logic [LevelW-1:0] red_level;
        logic [LevelW-1:0] green_level;
        logic [LevelW-1:0] yellow_level;
        logic              buzzer_on;
        light_mode_t       light_mode;
        event_t            event_code;
    } result_t;

    // Rational sine approximation of (1 + sin) / 2 * 255 for address q of a period h.
    // The quotient is at most 255, so it is found one bit at a time.
    function automatic logic [LevelW-1:0] fade_rom_entry(int unsigned q, int unsigned h);
        logic [63:0] u;
        logic [63:0] hh;
        logic [63:0] w;
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        logic        neg;
        hh  = 64'(h);
        u   = 64'(q) << 1;
        neg = 1'b0;
        if (u >= hh) begin
            u   = u - hh;
            neg = 1'b1;
        end
        if (u > hh) begin
            u = hh;
        end
        w = u * (hh - u);
        n = w << 4;
        d = 64'd5 * hh * hh - (w << 2);
        if (d == 64'd0) begin
            return LevelDark;
        end
        if (neg) begin
            num = (d >= n) ? 64'd255 * (d - n) : 64'd0;
        end else begin
            num = 64'd255 * (d + n);
        end
        den = d << 1;
        quo = 64'd0;
        for (int b = 8; b >= 0; b--) begin
            if (num >= ((quo | (64'd1 << b)) * den)) begin
                quo = quo | (64'd1 << b);
            end
        end
        return (quo > 64'd255) ? LevelFull : quo[LevelW-1:0];
    endfunction

    // Whole ROM image, one byte per address, unused addresses zero.
    function automatic logic [FadePeriodMax*LevelW-1:0] fade_rom_bits(int unsigned h);
        logic [FadePeriodMax*LevelW-1:0] bits;
        bits = '0;
        for (int unsigned q = 0; q < FadePeriodMax; q++) begin
            if (q < h) begin
                bits[q*LevelW +: LevelW] = fade_rom_entry(q, h);
            end
        end
        return bits;
    endfunction

endpackage

// ===== hw/rtl/lpbc_cfg_regs.sv =====
// Configuration register file of the LED pattern and button controller.
module lpbc_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [1:0]                 wr_index,
    input  logic [lpbc_pkg::CfgW-1:0]  wr_data,
    output lpbc_pkg::cfg_t             cfg
);
    import lpbc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blink_period <= BlinkPeriodReset;
            cfg_reg.debounce     <= DebounceReset;
            cfg_reg.long_press   <= LongPressReset;
            cfg_reg.tone         <= ToneReset;
        end else if (wr_en) begin
            case (cfg_index_t'(wr_index))
                CFG_BLINK_PERIOD: cfg_reg.blink_period <= wr_data;
                CFG_DEBOUNCE:     cfg_reg.debounce     <= wr_data;
                CFG_LONG_PRESS:   cfg_reg.long_press   <= wr_data;
                CFG_TONE:         cfg_reg.tone         <= wr_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/lpbc_fade_rom.sv =====
// Synchronous fade sine ROM with one registered read port.
module lpbc_fade_rom #(
    parameter int unsigned Period = lpbc_pkg::FadePeriodDefault
) (
    input  logic                        aclk,
    input  logic [$clog2(Period)-1:0]   rd_addr,
    output logic [lpbc_pkg::LevelW-1:0] rd_data
);
    import lpbc_pkg::*;

    localparam logic [FadePeriodMax*LevelW-1:0] RomBits = fade_rom_bits(Period);

    logic [LevelW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        rd_data_reg <= RomBits[{rd_addr, 3'b000} +: LevelW];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/lpbc_tick_core.sv =====
// Per-tick state update: debounce, mode sequencing, action press timing and LED patterns.
module lpbc_tick_core #(
    parameter int unsigned Period = lpbc_pkg::FadePeriodDefault
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  lpbc_pkg::buttons_t              buttons,
    input  lpbc_pkg::cfg_t                  cfg,
    input  logic [lpbc_pkg::LevelW-1:0]     rom_red,
    input  logic [lpbc_pkg::LevelW-1:0]     rom_green,
    input  logic [lpbc_pkg::LevelW-1:0]     rom_yellow,
    output logic [lpbc_pkg::FadePhaseW-1:0] rd_addr_red,
    output logic [lpbc_pkg::FadePhaseW-1:0] rd_addr_green,
    output logic [lpbc_pkg::FadePhaseW-1:0] rd_addr_yellow,
    output lpbc_pkg::result_t               result_next
);
    import lpbc_pkg::*;

    localparam int unsigned PhaseExtW = FadePhaseW + 1;
    localparam logic [PhaseExtW-1:0] PeriodV   = PhaseExtW'(Period);
    localparam logic [PhaseExtW-1:0] ThirdV    = PhaseExtW'(Period / 3);
    localparam logic [PhaseExtW-1:0] TwoThirdV = PhaseExtW'((2 * Period) / 3);
    localparam logic [LevelW-1:0] FadeRed0    = fade_rom_entry(0, Period);
    localparam logic [LevelW-1:0] FadeGreen0  = fade_rom_entry(Period / 3, Period);
    localparam logic [LevelW-1:0] FadeYellow0 = fade_rom_entry((2 * Period) / 3, Period);

    light_mode_t            mode_reg;
    logic                   override_active_reg;
    logic                   override_level_reg;
    logic                   blink_phase_reg;
    logic [1:0]             rotation_index_reg;
    logic [CfgW-1:0]        blink_counter_reg;
    logic [FadePhaseW-1:0]  fade_phase_reg;
    logic [CfgW-1:0]        hold_counter_reg;
    logic                   action_held_reg;
    logic                   long_done_reg;
    logic                   mode_latched_reg;
    logic                   boot_latched_reg;
    logic [CfgW-1:0]        mode_age_reg;
    logic [CfgW-1:0]        boot_age_reg;
    logic [CfgW-1:0]        tone_counter_reg;
    logic [2:0][LevelW-1:0] led_reg;

    light_mode_t            mode_next;
    logic                   override_active_next;
    logic                   override_level_next;
    logic                   blink_phase_next;
    logic [1:0]             rotation_index_next;
    logic [CfgW-1:0]        blink_counter_next;
    logic [FadePhaseW-1:0]  fade_phase_v;
    logic [FadePhaseW-1:0]  fade_phase_next;
    logic [CfgW-1:0]        hold_counter_next;
    logic                   action_held_next;
    logic                   long_done_next;
    logic                   mode_latched_next;
    logic                   boot_latched_next;
    logic [CfgW-1:0]        mode_age_next;
    logic [CfgW-1:0]        boot_age_next;
    logic [CfgW-1:0]        tone_counter_next;
    logic [2:0][LevelW-1:0] led_next;
    logic                   fade_cleared;
    logic                   mode_take;
    logic                   boot_take;
    event_t                 ev;

    logic [FadePhaseW-1:0]  addr_base;
    logic [PhaseExtW-1:0]   addr_r;
    logic [PhaseExtW-1:0]   addr_g;
    logic [PhaseExtW-1:0]   addr_y;

    always_comb begin
        mode_next            = mode_reg;
        override_active_next = override_active_reg;
        override_level_next  = override_level_reg;
        blink_phase_next     = blink_phase_reg;
        rotation_index_next  = rotation_index_reg;
        hold_counter_next    = hold_counter_reg;
        action_held_next     = action_held_reg;
        long_done_next       = long_done_reg;
        mode_latched_next    = mode_latched_reg;
        boot_latched_next    = boot_latched_reg;
        mode_age_next        = mode_age_reg;
        boot_age_next        = boot_age_reg;
        led_next             = led_reg;
        fade_cleared         = 1'b0;
        mode_take            = 1'b0;
        boot_take            = 1'b0;
        ev                   = EV_NONE;

        // Timers advance at the start of every tick.
        blink_counter_next = (blink_counter_reg == TimerSat) ? TimerSat
                                                             : blink_counter_reg + 16'd1;
        fade_phase_v = ({1'b0, fade_phase_reg} + 12'd1 >= PeriodV) ? '0
                                                                   : fade_phase_reg + 11'd1;
        tone_counter_next = (tone_counter_reg != '0) ? tone_counter_reg - 16'd1
                                                      : tone_counter_reg;

        // Mode button debounce.
        if (mode_latched_reg) begin
            if (!buttons.mode) begin
                mode_latched_next = 1'b0;
                mode_age_next     = '0;
            end
        end else begin
            mode_age_next = (mode_age_reg == TimerSat) ? TimerSat : mode_age_reg + 16'd1;
            if (buttons.mode && (mode_age_next > cfg.debounce)) begin
                mode_latched_next = 1'b1;
                mode_take         = 1'b1;
            end
        end

        if (mode_take) begin
            mode_next            = light_mode_t'(mode_reg + 2'd1);
            override_active_next = 1'b0;
            ev                   = EV_MODE;
            case (mode_next)
                LIGHT_OFF: led_next = {3{LevelDark}};
                LIGHT_ALT: begin
                    blink_counter_next = '0;
                    blink_phase_next   = 1'b0;
                end
                LIGHT_ALL_ON: led_next = {3{LevelFull}};
                LIGHT_FADE: begin
                    fade_phase_v = '0;
                    fade_cleared = 1'b1;
                end
                default: led_next = led_reg;
            endcase
        end

        // Boot button debounce; an accepted press forces the mode to off.
        if (boot_latched_reg) begin
            if (!buttons.boot) begin
                boot_latched_next = 1'b0;
                boot_age_next     = '0;
            end
        end else begin
            boot_age_next = (boot_age_reg == TimerSat) ? TimerSat : boot_age_reg + 16'd1;
            if (buttons.boot && (boot_age_next > cfg.debounce)) begin
                boot_latched_next = 1'b1;
                boot_take         = 1'b1;
            end
        end

        if (boot_take) begin
            mode_next            = LIGHT_OFF;
            override_active_next = 1'b0;
            led_next             = {3{LevelDark}};
            ev                   = EV_BOOT;
        end

        // Action button: long press sounds the buzzer, short press toggles the override.
        if (buttons.action) begin
            if (!action_held_reg) begin
                action_held_next  = 1'b1;
                hold_counter_next = '0;
                long_done_next    = 1'b0;
            end else begin
                hold_counter_next = (hold_counter_reg == TimerSat) ? TimerSat
                                                                   : hold_counter_reg + 16'd1;
            end
            if (!long_done_next && (hold_counter_next >= cfg.long_press)) begin
                long_done_next    = 1'b1;
                tone_counter_next = cfg.tone;
                ev                = EV_LONG;
            end
        end else if (action_held_reg) begin
            action_held_next = 1'b0;
            if (!long_done_reg && (((hold_counter_reg == TimerSat) ? TimerSat
                    : hold_counter_reg + 16'd1) < cfg.long_press)) begin
                override_active_next = 1'b1;
                override_level_next  = !override_level_reg;
                led_next             = override_level_next ? {3{LevelFull}} : {3{LevelDark}};
                ev                   = override_level_next ? EV_MAN_ON : EV_MAN_OFF;
            end
        end

        // Pattern logic runs only while the manual override is clear.
        if (!override_active_next) begin
            case (mode_next)
                LIGHT_ALT: begin
                    if (blink_counter_next >= cfg.blink_period) begin
                        blink_counter_next = '0;
                        blink_phase_next   = !blink_phase_next;
                        if (blink_phase_next) begin
                            rotation_index_next = (rotation_index_reg >= 2'd2) ? 2'd0
                                                  : rotation_index_reg + 2'd1;
                            led_next[0] = (rotation_index_next == 2'd0) ? LevelFull : LevelDark;
                            led_next[1] = (rotation_index_next == 2'd1) ? LevelFull : LevelDark;
                            led_next[2] = (rotation_index_next == 2'd2) ? LevelFull : LevelDark;
                        end else begin
                            led_next = {3{LevelDark}};
                        end
                    end
                end
                LIGHT_FADE: begin
                    if (fade_cleared) begin
                        led_next[0] = FadeRed0;
                        led_next[1] = FadeGreen0;
                        led_next[2] = FadeYellow0;
                    end else begin
                        led_next[0] = rom_red;
                        led_next[1] = rom_green;
                        led_next[2] = rom_yellow;
                    end
                end
                default: led_next = led_next;
            endcase
        end

        result_next.red_level    = led_next[0];
        result_next.green_level  = led_next[1];
        result_next.yellow_level = led_next[2];
        result_next.buzzer_on    = (tone_counter_next != '0);
        result_next.light_mode   = mode_next;
        result_next.event_code   = ev;
    end

    // The ROM is read one tick ahead: its registered data always belongs to the phase
    // that the next tick advances to.
    assign fade_phase_next = advance ? fade_phase_v : fade_phase_reg;

    always_comb begin
        addr_base = aresetn ? fade_phase_next : '0;
        addr_r    = ({1'b0, addr_base} + 12'd1 >= PeriodV) ? '0 : {1'b0, addr_base} + 12'd1;
        addr_g    = (addr_r + ThirdV >= PeriodV) ? addr_r + ThirdV - PeriodV : addr_r + ThirdV;
        addr_y    = (addr_r + TwoThirdV >= PeriodV) ? addr_r + TwoThirdV - PeriodV
                                                    : addr_r + TwoThirdV;
    end

    assign rd_addr_red    = addr_r[FadePhaseW-1:0];
    assign rd_addr_green  = addr_g[FadePhaseW-1:0];
    assign rd_addr_yellow = addr_y[FadePhaseW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg            <= LIGHT_OFF;
            override_active_reg <= 1'b0;
            override_level_reg  <= 1'b0;
            blink_phase_reg     <= 1'b0;
            rotation_index_reg  <= '0;
            blink_counter_reg   <= '0;
            fade_phase_reg      <= '0;
            hold_counter_reg    <= '0;
            action_held_reg     <= 1'b0;
            long_done_reg       <= 1'b0;
            mode_latched_reg    <= 1'b0;
            boot_latched_reg    <= 1'b0;
            mode_age_reg        <= TimerSat;
            boot_age_reg        <= TimerSat;
            tone_counter_reg    <= '0;
            led_reg             <= '0;
        end else if (advance) begin
            mode_reg            <= mode_next;
            override_active_reg <= override_active_next;
            override_level_reg  <= override_level_next;
            blink_phase_reg     <= blink_phase_next;
            rotation_index_reg  <= rotation_index_next;
            blink_counter_reg   <= blink_counter_next;
            fade_phase_reg      <= fade_phase_next;
            hold_counter_reg    <= hold_counter_next;
            action_held_reg     <= action_held_next;
            long_done_reg       <= long_done_next;
            mode_latched_reg    <= mode_latched_next;
            boot_latched_reg    <= boot_latched_next;
            mode_age_reg        <= mode_age_next;
            boot_age_reg        <= boot_age_next;
            tone_counter_reg    <= tone_counter_next;
            led_reg             <= led_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && result_next.event_code == EV_MODE)
            |-> (result_next.light_mode == light_mode_t'(mode_reg + 2'd1)))
        else $error("mode event without a step to the next mode");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && result_next.event_code == EV_BOOT) |=> (mode_reg == LIGHT_OFF))
        else $error("boot event did not force the mode to off");

    assert property (@(posedge aclk) disable iff (!aresetn)
        override_active_reg |-> (led_reg[0] == led_reg[1] && led_reg[1] == led_reg[2]))
        else $error("manual override with unequal LED levels");
`endif

endmodule

// ===== hw/rtl/led_pattern_button_controller.sv =====
// Top level of the LED pattern and button controller: item stages, config port and ROMs.
// An accepted item waits in the input stage register, moves into the result register when
// that register is empty or being drained, and is offered on m_* from there.
// Throughput: one item per clock while m_ready stays high, set by the tick update between
// the input stage register and the result register; the fade ROMs are read one tick ahead.
// Reset: synchronous, active low; clears all control state and the configuration registers
// to their defaults, with no clearing pass.
module led_pattern_button_controller #(
    parameter int unsigned FADE_PERIOD = lpbc_pkg::FadePeriodDefault
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_mode_pressed,
    input  logic                       s_action_pressed,
    input  logic                       s_boot_pressed,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lpbc_pkg::LevelW-1:0] m_red_level,
    output logic [lpbc_pkg::LevelW-1:0] m_green_level,
    output logic [lpbc_pkg::LevelW-1:0] m_yellow_level,
    output logic                       m_buzzer_on,
    output logic [1:0]                 m_light_mode,
    output logic [2:0]                 m_event_code,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [lpbc_pkg::CfgW-1:0]  cfg_data
);
    import lpbc_pkg::*;

    localparam int unsigned AddrW = $clog2(FADE_PERIOD);

    // The input stage holds one item; the result register holds one finished item.
    // An item moves from one to the other, and updates the tick state, whenever the
    // result register is empty or being drained in the same cycle.
    logic     in_valid_reg;
    buttons_t in_buttons_reg;
    logic     out_valid_reg;
    result_t  out_result_reg;

    logic     advance;
    result_t  result_next;
    cfg_t     cfg;

    logic [FadePhaseW-1:0] rd_addr_red;
    logic [FadePhaseW-1:0] rd_addr_green;
    logic [FadePhaseW-1:0] rd_addr_yellow;
    logic [LevelW-1:0]     rom_red;
    logic [LevelW-1:0]     rom_green;
    logic [LevelW-1:0]     rom_yellow;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_buttons_reg <= '{mode: s_mode_pressed, action: s_action_pressed,
                                boot: s_boot_pressed};
        end
        if (advance) begin
            out_result_reg <= result_next;
        end
    end

    lpbc_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Three copies of the sine ROM, one per LED, each read at its own phase offset.
    lpbc_fade_rom #(.Period(FADE_PERIOD)) u_rom_red (
        .aclk    (aclk),
        .rd_addr (rd_addr_red[AddrW-1:0]),
        .rd_data (rom_red)
    );

    lpbc_fade_rom #(.Period(FADE_PERIOD)) u_rom_green (
        .aclk    (aclk),
        .rd_addr (rd_addr_green[AddrW-1:0]),
        .rd_data (rom_green)
    );

    lpbc_fade_rom #(.Period(FADE_PERIOD)) u_rom_yellow (
        .aclk    (aclk),
        .rd_addr (rd_addr_yellow[AddrW-1:0]),
        .rd_data (rom_yellow)
    );

    lpbc_tick_core #(.Period(FADE_PERIOD)) u_tick_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .buttons        (in_buttons_reg),
        .cfg            (cfg),
        .rom_red        (rom_red),
        .rom_green      (rom_green),
        .rom_yellow     (rom_yellow),
        .rd_addr_red    (rd_addr_red),
        .rd_addr_green  (rd_addr_green),
        .rd_addr_yellow (rd_addr_yellow),
        .result_next    (result_next)
    );

    assign m_valid        = out_valid_reg;
    assign m_red_level    = out_result_reg.red_level;
    assign m_green_level  = out_result_reg.green_level;
    assign m_yellow_level = out_result_reg.yellow_level;
    assign m_buzzer_on    = out_result_reg.buzzer_on;
    assign m_light_mode   = out_result_reg.light_mode;
    assign m_event_code   = out_result_reg.event_code;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input refused although the item stages could move");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=> (in_valid_reg && $stable(in_buttons_reg)))
        else $error("stalled item lost or changed in the input stage");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without an item in the input stage");
`endif

endmodule

// ===== bench/tb_led_pattern_button_controller.sv =====
// Self-checking testbench for the LED pattern and button controller, driven tick by tick.
module tb_led_pattern_button_controller;

    import lpbc_pkg::*;

    // The fade period of the instance; the predictor's sine table uses the same value.
    localparam int unsigned FADE_TICKS = 2000;
    // Cycles without any handshake before the run is declared hung.
    localparam int unsigned QUIET_LIMIT = 2000;
    // Length of the one long receiver hold-off that backs the block up.
    localparam int unsigned LONG_HOLD = 150;
    // Button ticks queued per random phase.
    localparam int unsigned PHASE_TICKS = 80;

    localparam buttons_t NO_BTN   = '{mode: 1'b0, action: 1'b0, boot: 1'b0};
    localparam buttons_t MODE_BTN = '{mode: 1'b1, action: 1'b0, boot: 1'b0};
    localparam buttons_t ACT_BTN  = '{mode: 1'b0, action: 1'b1, boot: 1'b0};
    localparam buttons_t BOOT_BTN = '{mode: 1'b0, action: 1'b0, boot: 1'b1};
    localparam buttons_t ALL_BTN  = '{mode: 1'b1, action: 1'b1, boot: 1'b1};

    logic aclk;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    logic s_mode_pressed = 1'b0;
    logic s_action_pressed = 1'b0;
    logic s_boot_pressed = 1'b0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [LevelW-1:0] m_red_level;
    logic [LevelW-1:0] m_green_level;
    logic [LevelW-1:0] m_yellow_level;
    logic              m_buzzer_on;
    logic [1:0]        m_light_mode;
    logic [2:0]        m_event_code;

    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [1:0]      cfg_index = CFG_BLINK_PERIOD;
    logic [CfgW-1:0] cfg_data = '0;

    led_pattern_button_controller #(
        .FADE_PERIOD(FADE_TICKS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode_pressed  (s_mode_pressed),
        .s_action_pressed(s_action_pressed),
        .s_boot_pressed  (s_boot_pressed),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red_level     (m_red_level),
        .m_green_level   (m_green_level),
        .m_yellow_level  (m_yellow_level),
        .m_buzzer_on     (m_buzzer_on),
        .m_light_mode    (m_light_mode),
        .m_event_code    (m_event_code),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the controller state, advanced once per accepted item.
    // ------------------------------------------------------------------
    logic [CfgW-1:0] cfg_blink;
    logic [CfgW-1:0] cfg_debounce;
    logic [CfgW-1:0] cfg_long;
    logic [CfgW-1:0] cfg_tone;

    light_mode_t     mode_q;
    logic            override_on;
    logic            override_lvl;
    logic            blink_ph;
    logic [1:0]      rot_idx;
    logic [15:0]     blink_cnt;
    logic [10:0]     fade_ph;
    logic [15:0]     hold_cnt;
    logic            action_down;
    logic            long_fired;
    // Index 0 is the mode button, index 1 the boot button; both debounce alike.
    logic [1:0]      btn_down;
    logic [15:0]     btn_age [2];
    logic [15:0]     tone_cnt;
    logic [LevelW-1:0] leds [3];

    // Stimulus and scoreboard bookkeeping.
    buttons_t    pending_ticks [$];
    result_t     results_due [$];
    buttons_t    next_tick;
    result_t     want;
    int unsigned ticks_queued = 0;
    int unsigned ticks_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    bit          tick_taken = 1'b0;
    bit          stall_request = 1'b0;
    int unsigned held_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v == TimerSat) ? v : v + 16'd1;
    endfunction

    function automatic void set_leds(logic [LevelW-1:0] v);
        for (int k = 0; k < 3; k++) begin
            leds[k] = v;
        end
    endfunction

    // Rational sine approximation of (1 + sin) / 2 * 255, exact in integers.
    // The second half of the period mirrors the first around mid scale.
    function automatic logic [LevelW-1:0] sine_level(int unsigned addr);
        longint unsigned per;
        longint unsigned x;
        longint unsigned w;
        longint unsigned den;
        longint unsigned num;
        longint unsigned lvl;
        bit              lower;
        per   = FADE_TICKS;
        x     = 2 * longint'(addr);
        lower = 1'b0;
        if (x >= per) begin
            x     = x - per;
            lower = 1'b1;
        end
        w   = x * (per - x);
        den = 5 * per * per - 4 * w;
        if (lower) begin
            num = (den >= 16 * w) ? 255 * (den - 16 * w) : 0;
        end else begin
            num = 255 * (den + 16 * w);
        end
        lvl = num / (2 * den);
        return (lvl > 255) ? LevelFull : lvl[LevelW-1:0];
    endfunction

    function automatic void reset_model();
        cfg_blink    = BlinkPeriodReset;
        cfg_debounce = DebounceReset;
        cfg_long     = LongPressReset;
        cfg_tone     = ToneReset;
        mode_q       = LIGHT_OFF;
        override_on  = 1'b0;
        override_lvl = 1'b0;
        blink_ph     = 1'b0;
        rot_idx      = 2'd0;
        blink_cnt    = '0;
        fade_ph      = '0;
        hold_cnt     = '0;
        action_down  = 1'b0;
        long_fired   = 1'b0;
        btn_down     = 2'b00;
        btn_age[0]   = TimerSat;
        btn_age[1]   = TimerSat;
        tone_cnt     = '0;
        set_leds(LevelDark);
    endfunction

    // A new mode always drops the manual override. Alternate and fade keep the LEDs until
    // the pattern logic rewrites them: fade in the same tick, alternate at its next blink step.
    function automatic void enter_mode(light_mode_t m);
        mode_q      = m;
        override_on = 1'b0;
        case (m)
            LIGHT_OFF: begin
                set_leds(LevelDark);
            end
            LIGHT_ALT: begin
                blink_cnt = '0;
                blink_ph  = 1'b0;
            end
            LIGHT_ALL_ON: begin
                set_leds(LevelFull);
            end
            LIGHT_FADE: begin
                fade_ph = '0;
            end
            default: begin
                set_leds(LevelDark);
            end
        endcase
    endfunction

    // One millisecond tick: timers, mode button, boot button, action button,
    // then the light pattern. The last event raised in that order is reported.
    function automatic result_t advance_tick(buttons_t b);
        result_t     r;
        event_t      ev;
        logic [1:0]  pressed;
        logic [1:0]  nxt;
        logic [15:0] dur;
        int unsigned ph;
        ev = EV_NONE;

        blink_cnt = sat_inc(blink_cnt);
        fade_ph   = (fade_ph + 11'd1 >= FADE_TICKS) ? 11'd0 : fade_ph + 11'd1;
        if (tone_cnt != '0) begin
            tone_cnt = tone_cnt - 16'd1;
        end

        pressed = {b.boot, b.mode};
        for (int i = 0; i < 2; i++) begin
            if (btn_down[i]) begin
                if (!pressed[i]) begin
                    btn_down[i] = 1'b0;
                    btn_age[i]  = '0;
                end
            end else begin
                btn_age[i] = sat_inc(btn_age[i]);
                if (pressed[i] && btn_age[i] > cfg_debounce) begin
                    btn_down[i] = 1'b1;
                    if (i == 0) begin
                        nxt = mode_q + 2'd1;
                        enter_mode(light_mode_t'(nxt));
                        ev = EV_MODE;
                    end else begin
                        enter_mode(LIGHT_OFF);
                        ev = EV_BOOT;
                    end
                end
            end
        end

        if (b.action) begin
            if (!action_down) begin
                action_down = 1'b1;
                hold_cnt    = '0;
                long_fired  = 1'b0;
            end else begin
                hold_cnt = sat_inc(hold_cnt);
            end
            if (!long_fired && hold_cnt >= cfg_long) begin
                long_fired = 1'b1;
                tone_cnt   = cfg_tone;
                ev         = EV_LONG;
            end
        end else if (action_down) begin
            // The release tick itself counts toward the press length.
            dur         = sat_inc(hold_cnt);
            action_down = 1'b0;
            if (!long_fired && dur < cfg_long) begin
                override_on  = 1'b1;
                override_lvl = ~override_lvl;
                set_leds(override_lvl ? LevelFull : LevelDark);
                ev = override_lvl ? EV_MAN_ON : EV_MAN_OFF;
            end
        end

        if (!override_on) begin
            if (mode_q == LIGHT_ALT) begin
                if (blink_cnt >= cfg_blink) begin
                    blink_cnt = '0;
                    blink_ph  = ~blink_ph;
                    if (blink_ph) begin
                        rot_idx = (rot_idx >= 2'd2) ? 2'd0 : rot_idx + 2'd1;
                        for (int k = 0; k < 3; k++) begin
                            leds[k] = (rot_idx == k) ? LevelFull : LevelDark;
                        end
                    end else begin
                        set_leds(LevelDark);
                    end
                end
            end else if (mode_q == LIGHT_FADE) begin
                ph      = fade_ph;
                leds[0] = sine_level(ph);
                leds[1] = sine_level((ph + FADE_TICKS / 3) % FADE_TICKS);
                leds[2] = sine_level((ph + (2 * FADE_TICKS) / 3) % FADE_TICKS);
            end
        end

        r.red_level    = leds[0];
        r.green_level  = leds[1];
        r.yellow_level = leds[2];
        r.buzzer_on    = (tone_cnt != '0);
        r.light_mode   = mode_q;
        r.event_code   = ev;
        return r;
    endfunction

    function automatic bit field_differs(string name, logic [7:0] exp_v, logic [7:0] got_v);
        if (got_v === exp_v) begin
            return 1'b0;
        end
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch in result %0d, %s: expected %0d, got %0d",
                     results_seen, name, exp_v, got_v);
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued ticks at the falling edge. An item stays on
    // the port, unchanged, until the rising edge that accepts it.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!s_valid || tick_taken) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_tick = pending_ticks.pop_front();
                s_valid          <= 1'b1;
                s_mode_pressed   <= next_tick.mode;
                s_action_pressed <= next_tick.action;
                s_boot_pressed   <= next_tick.boot;
            end else begin
                s_valid <= 1'b0;
            end
        end
        tick_taken = 1'b0;
    end

    // Receiver: random back-pressure, plus one long hold-off when requested,
    // counted here so that the sender keeps pushing while the block backs up.
    always @(negedge aclk) begin
        if (stall_request && held_cycles < LONG_HOLD) begin
            held_cycles++;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. Results are checked
    // before the new item's prediction is queued, so an extra result can
    // never be matched against an item accepted in the same cycle.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d arrived with no item waiting for it",
                                 results_seen);
                    end
                end else begin
                    want = results_due.pop_front();
                    void'(field_differs("red_level", want.red_level, m_red_level));
                    void'(field_differs("green_level", want.green_level, m_green_level));
                    void'(field_differs("yellow_level", want.yellow_level, m_yellow_level));
                    void'(field_differs("buzzer_on", want.buzzer_on, m_buzzer_on));
                    void'(field_differs("light_mode", want.light_mode, m_light_mode));
                    void'(field_differs("event_code", want.event_code, m_event_code));
                end
            end
            if (s_valid && s_ready) begin
                results_due.push_back(advance_tick(
                    buttons_t'({s_mode_pressed, s_action_pressed, s_boot_pressed})));
                ticks_accepted++;
                tick_taken = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_BLINK_PERIOD: cfg_blink    = cfg_data;
                    CFG_DEBOUNCE:     cfg_debounce = cfg_data;
                    CFG_LONG_PRESS:   cfg_long     = cfg_data;
                    CFG_TONE:         cfg_tone     = cfg_data;
                    default:          cfg_tone     = cfg_tone;
                endcase
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_ticks(buttons_t b, int unsigned n);
        repeat (n) begin
            pending_ticks.push_back(b);
            ticks_queued++;
        end
    endtask

    // Waits until every queued item has been taken and every result checked.
    task automatic settle();
        do begin
            @(negedge aclk);
        end while (ticks_accepted != ticks_queued || results_due.size() != 0);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CfgW-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
    endtask

    task automatic write_settings(logic [CfgW-1:0] blink, logic [CfgW-1:0] debounce,
                                  logic [CfgW-1:0] long_press, logic [CfgW-1:0] tone);
        write_reg(CFG_BLINK_PERIOD, blink);
        write_reg(CFG_DEBOUNCE, debounce);
        write_reg(CFG_LONG_PRESS, long_press);
        write_reg(CFG_TONE, tone);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random button gestures. Most are clean presses whose lengths straddle
    // the long-press threshold and whose release gaps straddle the debounce
    // window; the rest are random button noise and quiet stretches.
    task automatic queue_gestures(int unsigned count);
        int unsigned start;
        int unsigned press_span;
        int unsigned gap_span;
        start      = ticks_queued;
        press_span = 2 * int'(cfg_long) + 2;
        if (press_span > 48) begin
            press_span = 48;
        end
        gap_span = int'(cfg_debounce) + 4;
        if (gap_span > 12) begin
            gap_span = 12;
        end
        while (ticks_queued - start < count) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    queue_ticks(ACT_BTN, $urandom_range(1, press_span));
                    queue_ticks(NO_BTN, $urandom_range(1, 3));
                end
                3, 4: begin
                    queue_ticks(MODE_BTN, $urandom_range(1, 3));
                    queue_ticks(NO_BTN, $urandom_range(1, gap_span));
                end
                5: begin
                    queue_ticks(BOOT_BTN, $urandom_range(1, 3));
                    queue_ticks(NO_BTN, $urandom_range(1, gap_span));
                end
                6, 7: begin
                    repeat ($urandom_range(1, 6)) begin
                        queue_ticks(buttons_t'(3'($urandom_range(7))), 1);
                    end
                end
                default: begin
                    queue_ticks(NO_BTN, $urandom_range(1, 6));
                end
            endcase
        end
    endtask

    task automatic run_phase(logic [CfgW-1:0] blink, logic [CfgW-1:0] debounce,
                             logic [CfgW-1:0] long_press, logic [CfgW-1:0] tone,
                             int unsigned send_pct, int unsigned recv_pct);
        settle();
        write_settings(blink, debounce, long_press, tone);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        queue_gestures(PHASE_TICKS);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        reset_model();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed ticks with short timings: blink 2, debounce 1, long press 4,
        // tone 3. The mode button walks through all four modes with one bounce
        // rejected inside the debounce window, boot forces off, two short
        // action presses switch the override on and off, a long one sounds the
        // buzzer, and finally all three buttons are pressed in the same tick.
        write_settings(16'd2, 16'd1, 16'd4, 16'd3);
        queue_ticks(MODE_BTN, 2);
        queue_ticks(NO_BTN, 2);
        queue_ticks(MODE_BTN, 1);
        queue_ticks(NO_BTN, 1);
        queue_ticks(MODE_BTN, 1);
        queue_ticks(NO_BTN, 2);
        queue_ticks(MODE_BTN, 1);
        queue_ticks(NO_BTN, 2);
        queue_ticks(MODE_BTN, 1);
        queue_ticks(BOOT_BTN, 1);
        queue_ticks(ACT_BTN, 2);
        queue_ticks(NO_BTN, 1);
        queue_ticks(ACT_BTN, 1);
        queue_ticks(NO_BTN, 1);
        queue_ticks(ACT_BTN, 5);
        queue_ticks(ALL_BTN, 1);

        // Smallest settings with no idling: every tick blinks, presses are
        // never debounced, and every held action press is long.
        run_phase(16'd1, 16'd0, 16'd1, 16'd0, 0, 0);

        // Small random timings with an idle sender.
        run_phase(16'($urandom_range(1, 6)), 16'($urandom_range(0, 4)),
                  16'($urandom_range(2, 12)), 16'($urandom_range(0, 10)), 65, 0);

        // Stalling receiver; the long hold-off lets the block fill up and push
        // back on the sender while it still has items to offer.
        settle();
        write_settings(16'($urandom_range(1, 6)), 16'($urandom_range(0, 4)),
                       16'($urandom_range(2, 12)), 16'($urandom_range(0, 10)));
        send_idle_pct = 0;
        stall_pct     = 65;
        stall_request = 1'b1;
        queue_gestures(PHASE_TICKS);

        // Largest settings: mode and boot presses are never accepted, no press
        // becomes long, and a started tone never ends within the run.
        run_phase(TimerSat, TimerSat, TimerSat, TimerSat, 35, 35);

        run_phase(16'($urandom_range(1, 6)), 16'($urandom_range(0, 4)),
                  16'($urandom_range(2, 12)), 16'($urandom_range(0, 10)), 35, 35);

        // Longer timings with no idling; halfway through the sender stops
        // until every outstanding result has come back.
        settle();
        write_settings(16'($urandom_range(20, 60)), 16'($urandom_range(5, 20)),
                       16'($urandom_range(15, 30)), 16'($urandom_range(5, 40)));
        send_idle_pct = 0;
        stall_pct     = 0;
        queue_gestures(PHASE_TICKS / 2);
        settle();
        queue_gestures(PHASE_TICKS / 2);

        settle();
        // The wait below catches any stray result.
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
